// File: hdl/nrpd_pkg.sv
// Package with widths, status codes and defaults for the ring parameter derivation block.
`default_nettype none
package nrpd_pkg;
	localparam int Q_WIDTH_DEFAULT = 16;
	localparam int FIELD_W = 16;
	localparam int BITS_W = 5;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_PRIME = 2'd1;
	localparam logic [1:0] ST_NO_DIVIDE = 2'd2;
	localparam logic [1:0] ST_NO_ROOT = 2'd3;

	// Request to one of the shared units (divider or modular power).
	typedef struct packed {
		logic go;
		logic is_pow;
	} nrpd_req_t;
endpackage
`default_nettype wire

// File: hdl/nrpd_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none
module nrpd_divider #(
	parameter int W = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic go,
	input wire logic [W-1:0] dividend,
	input wire logic [W-1:0] divisor,
	output logic done,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);
	import nrpd_pkg::*;
	localparam int CW = $clog2(W + 1);

	logic [W-1:0] quo_q;
	logic [W-1:0] rem_q;
	logic [W-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic run_q;
	logic [W:0] trial;

	// Shift the next dividend bit into the partial remainder and try the subtract.
	always_comb begin
		trial = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

// File: hdl/nrpd_modmul.sv
// Bit-serial modular multiplier and square-and-multiply exponentiation.
`default_nettype none
module nrpd_modmul #(
	parameter int W = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic go,
	input wire logic [W-1:0] base,
	input wire logic [W-1:0] expo,
	input wire logic [W-1:0] modulus,
	output logic done,
	output logic [W-1:0] power
);
	import nrpd_pkg::*;
	localparam int CW = $clog2(W + 1);
	localparam logic [2:0] P_IDLE = 3'd0;
	localparam logic [2:0] P_MULR = 3'd1;
	localparam logic [2:0] P_SQR = 3'd2;
	localparam logic [2:0] P_NEXT = 3'd3;

	logic [2:0] st_q;
	logic [W-1:0] res_q;
	logic [W-1:0] bas_q;
	logic [W-1:0] exp_q;
	logic [W-1:0] mod_q;
	// Serial multiply: acc = acc*2 + bit*y, reduced every step (MSB first).
	logic [W-1:0] acc_q;
	logic [W-1:0] x_q;
	logic [W-1:0] y_q;
	logic [CW-1:0] cnt_q;
	logic [W+1:0] dbl;
	logic [W+1:0] add;
	logic [W+1:0] red1;
	logic [W+1:0] red2;
	logic [W-1:0] step;

	// Double, add, and reduce with at most two subtracts since both parts stay below m.
	always_comb begin
		dbl = {2'b0, acc_q} << 1;
		if (dbl >= {2'b0, mod_q}) dbl = dbl - {2'b0, mod_q};
		add = dbl + (x_q[W-1] ? {2'b0, y_q} : '0);
		red1 = add;
		if (red1 >= {2'b0, mod_q}) red1 = red1 - {2'b0, mod_q};
		red2 = red1;
		step = red2[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= P_IDLE;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			case (st_q)
				P_IDLE: begin
					if (go) st_q <= P_NEXT;
				end
				P_NEXT: begin
					if (exp_q == '0) begin
						st_q <= P_IDLE;
						done <= 1'b1;
					end else if (exp_q[0]) begin
						st_q <= P_MULR;
						cnt_q <= CW'(W);
					end else begin
						st_q <= P_SQR;
						cnt_q <= CW'(W);
					end
				end
				P_MULR: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						st_q <= P_SQR;
						cnt_q <= CW'(W);
					end
				end
				P_SQR: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) st_q <= P_NEXT;
				end
				default: st_q <= P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			P_IDLE: begin
				if (go) begin
					mod_q <= modulus;
					exp_q <= expo;
					// Base is below the modulus for every caller.
					bas_q <= base;
					res_q <= (modulus == W'(1)) ? '0 : W'(1);
				end
			end
			P_NEXT: begin
				acc_q <= '0;
				if (exp_q[0]) begin
					x_q <= res_q;
					y_q <= bas_q;
				end else begin
					x_q <= bas_q;
					y_q <= bas_q;
				end
			end
			P_MULR: begin
				acc_q <= step;
				x_q <= {x_q[W-2:0], 1'b0};
				if (cnt_q == CW'(1)) begin
					res_q <= step;
					acc_q <= '0;
					x_q <= bas_q;
					y_q <= bas_q;
				end
			end
			P_SQR: begin
				acc_q <= step;
				x_q <= {x_q[W-2:0], 1'b0};
				if (cnt_q == CW'(1)) begin
					bas_q <= step;
					exp_q <= exp_q >> 1;
				end
			end
			default: ;
		endcase
	end

	assign power = res_q;
endmodule
`default_nettype wire

// File: hdl/ntt_ring_parameter_derivation.sv
// Top level: sequencer for primality, divisibility, root search, inverses and modulus bit count.
//
//  channel  | signals                                   | direction
//  command  | start, busy, modulus, ring_size            | in (busy out)
//  result   | done, status, modulus_bits, root_of_unity, | out, one-cycle strobe
//           | size_inverse, half_size_inverse            |
//
// Trial division runs over the divisors up to sqrt(q), and each candidate of the
// root search costs one or more modular powers, all on the single shared divider
// and serial multiplier.
// Reset clears the sequencer; busy is low after reset.
// The receiver cannot stall; a new word is accepted once busy is low again.
`default_nettype none
module ntt_ring_parameter_derivation #(
	parameter int Q_WIDTH = nrpd_pkg::Q_WIDTH_DEFAULT
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [nrpd_pkg::FIELD_W-1:0] modulus,
	input wire logic [nrpd_pkg::FIELD_W-1:0] ring_size,
	output logic done,
	output logic [1:0] status,
	output logic [nrpd_pkg::BITS_W-1:0] modulus_bits,
	output logic [nrpd_pkg::FIELD_W-1:0] root_of_unity,
	output logic [nrpd_pkg::FIELD_W-1:0] size_inverse,
	output logic [nrpd_pkg::FIELD_W-1:0] half_size_inverse
);
	import nrpd_pkg::*;
	localparam int W = Q_WIDTH + 1;
	localparam int IW = (Q_WIDTH < FIELD_W) ? Q_WIDTH : FIELD_W;
	localparam int BW = $clog2(W + 1);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_PR_CHK = 5'd1;
	localparam logic [4:0] S_PR_WAIT = 5'd2;
	localparam logic [4:0] S_DIVN = 5'd3;
	localparam logic [4:0] S_DIVN_W = 5'd4;
	localparam logic [4:0] S_DIV2N = 5'd5;
	localparam logic [4:0] S_DIV2N_W = 5'd6;
	localparam logic [4:0] S_CAND = 5'd7;
	localparam logic [4:0] S_CP_FULL = 5'd8;
	localparam logic [4:0] S_CP_FULL_W = 5'd9;
	localparam logic [4:0] S_FAC_CHK = 5'd10;
	localparam logic [4:0] S_FAC_DIV = 5'd11;
	localparam logic [4:0] S_FAC_W = 5'd12;
	localparam logic [4:0] S_STRIP = 5'd13;
	localparam logic [4:0] S_STRIP_W = 5'd14;
	localparam logic [4:0] S_SUBQ = 5'd15;
	localparam logic [4:0] S_SUBQ_W = 5'd16;
	localparam logic [4:0] S_SUBP = 5'd17;
	localparam logic [4:0] S_SUBP_W = 5'd18;
	localparam logic [4:0] S_INVN = 5'd19;
	localparam logic [4:0] S_INVN_W = 5'd20;
	localparam logic [4:0] S_INVH = 5'd21;
	localparam logic [4:0] S_INVH_W = 5'd22;
	localparam logic [4:0] S_BITS = 5'd23;
	localparam logic [4:0] S_OUT = 5'd24;

	logic [4:0] st_q;
	logic [W-1:0] q_q;
	logic [W-1:0] n_q;
	logic [W-1:0] ord_q;
	logic [W-1:0] d_q;
	logic [W-1:0] rest_q;
	logic [W-1:0] c_q;
	logic [W-1:0] inv_n_q;
	logic [W-1:0] inv_h_q;
	logic [W-1:0] t_q;
	logic [BW-1:0] bits_q;
	logic [1:0] status_q;
	logic first_q;

	// Shared divider.
	nrpd_req_t dreq;
	logic [W-1:0] d_a;
	logic [W-1:0] d_b;
	logic d_done;
	logic [W-1:0] d_quo;
	logic [W-1:0] d_rem;
	nrpd_divider #(.W(W)) u_div (
		.clk(clk), .arst_n(arst_n), .go(dreq.go), .dividend(d_a), .divisor(d_b),
		.done(d_done), .quotient(d_quo), .remainder(d_rem)
	);

	// Shared modular exponentiation.
	nrpd_req_t preq;
	logic [W-1:0] p_b;
	logic [W-1:0] p_e;
	logic p_done;
	logic [W-1:0] p_pow;
	nrpd_modmul #(.W(W)) u_pow (
		.clk(clk), .arst_n(arst_n), .go(preq.go), .base(p_b), .expo(p_e),
		.modulus(q_q), .done(p_done), .power(p_pow)
	);

	logic [2*W-1:0] d_sq;
	assign d_sq = d_q * d_q;

	// Operand selection for the two shared units.
	always_comb begin
		dreq = '{go: 1'b0, is_pow: 1'b0};
		preq = '{go: 1'b0, is_pow: 1'b1};
		d_a = q_q;
		d_b = d_q;
		p_b = c_q;
		p_e = ord_q;
		case (st_q)
			S_PR_CHK: dreq.go = (d_sq <= {{W{1'b0}}, q_q}) && (q_q >= W'(2));
			S_DIVN: begin
				dreq.go = (n_q != '0);
				d_a = q_q - W'(1);
				d_b = n_q;
			end
			S_DIV2N: begin
				dreq.go = 1'b1;
				d_a = q_q - W'(1);
				d_b = ord_q;
			end
			S_CP_FULL: preq.go = 1'b1;
			S_FAC_DIV: begin
				dreq.go = 1'b1;
				d_a = rest_q;
			end
			S_STRIP: begin
				dreq.go = 1'b1;
				d_a = rest_q;
			end
			S_SUBP: begin
				dreq.go = 1'b1;
				d_a = ord_q;
			end
			// The quotient ord/p starts the power check of the candidate.
			S_SUBP_W: begin
				if (d_done) begin
					preq.go = 1'b1;
					p_e = d_quo;
				end
			end
			S_SUBQ: begin
				dreq.go = 1'b1;
				d_a = ord_q;
				d_b = rest_q;
			end
			S_SUBQ_W: begin
				if (!first_q && d_done) begin
					preq.go = 1'b1;
					p_e = d_quo;
				end
			end
			S_INVN: begin
				preq.go = 1'b1;
				p_b = n_q;
				p_e = q_q - W'(2);
			end
			S_INVH: begin
				preq.go = 1'b1;
				p_b = n_q >> 1;
				p_e = q_q - W'(2);
			end
			default: ;
		endcase
		if (!dreq.go) d_b = d_q;
		if (preq.is_pow && !preq.go) p_e = ord_q;
		if (dreq.is_pow) d_a = q_q;
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (st_q)
				S_IDLE: if (start) st_q <= S_PR_CHK;
				S_PR_CHK: begin
					if (q_q < W'(2)) st_q <= S_OUT;
					else if (d_sq > {{W{1'b0}}, q_q}) st_q <= S_DIVN;
					else st_q <= S_PR_WAIT;
				end
				S_PR_WAIT: if (d_done) st_q <= (d_rem == '0) ? S_OUT : S_PR_CHK;
				S_DIVN: st_q <= (n_q == '0) ? S_OUT : S_DIVN_W;
				S_DIVN_W: if (d_done) st_q <= (d_rem != '0) ? S_OUT : S_DIV2N;
				S_DIV2N: st_q <= S_DIV2N_W;
				S_DIV2N_W: if (d_done) st_q <= (d_rem != '0) ? S_OUT : S_CAND;
				S_CAND: st_q <= (c_q >= q_q) ? S_OUT : S_CP_FULL;
				S_CP_FULL: st_q <= S_CP_FULL_W;
				S_CP_FULL_W: if (p_done) st_q <= (p_pow == W'(1)) ? S_FAC_CHK : S_CAND;
				S_FAC_CHK: begin
					if (d_sq > {{W{1'b0}}, rest_q}) begin
						st_q <= (rest_q > W'(1)) ? S_SUBQ : S_INVN;
					end else begin
						st_q <= S_FAC_DIV;
					end
				end
				S_FAC_DIV: st_q <= S_FAC_W;
				S_FAC_W: if (d_done) st_q <= (d_rem == '0) ? S_SUBP : S_FAC_CHK;
				S_SUBP: st_q <= S_SUBP_W;
				S_SUBP_W: if (d_done) st_q <= S_SUBQ_W;
				// The leftover prime factor is the last check; a small factor is stripped.
				S_SUBQ_W: begin
					if (first_q) begin
						if (p_done) begin
							if (p_pow == W'(1)) st_q <= S_CAND;
							else if (d_sq > {{W{1'b0}}, rest_q}) st_q <= S_INVN;
							else st_q <= S_STRIP;
						end
					end else if (d_done) begin
						st_q <= S_SUBQ_W;
					end
				end
				S_STRIP: st_q <= S_STRIP_W;
				S_STRIP_W: if (d_done) st_q <= (d_rem == '0) ? S_STRIP : S_FAC_CHK;
				S_SUBQ: st_q <= S_SUBQ_W;
				S_INVN: st_q <= S_INVN_W;
				S_INVN_W: if (p_done) st_q <= S_INVH;
				S_INVH: st_q <= S_INVH_W;
				S_INVH_W: if (p_done) st_q <= S_BITS;
				S_BITS: if (t_q == '0) st_q <= S_OUT;
				S_OUT: begin
					st_q <= S_IDLE;
					done <= 1'b1;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				q_q <= W'(modulus[IW-1:0]);
				n_q <= W'(ring_size[IW-1:0]);
				ord_q <= W'(ring_size[IW-1:0]) << 1;
				d_q <= W'(2);
				c_q <= W'(2);
				status_q <= ST_NOT_PRIME;
				inv_n_q <= '0;
				inv_h_q <= '0;
				bits_q <= '0;
				first_q <= 1'b0;
			end
			S_PR_CHK: if (d_sq > {{W{1'b0}}, q_q} && q_q >= W'(2)) status_q <= ST_NO_DIVIDE;
			S_PR_WAIT: if (d_done) d_q <= d_q + W'(1);
			S_DIVN_W: if (d_done && d_rem == '0) status_q <= ST_NO_ROOT;
			S_CAND: begin
				rest_q <= ord_q;
				d_q <= W'(2);
			end
			S_CP_FULL_W: if (p_done && p_pow != W'(1)) c_q <= c_q + W'(1);
			S_FAC_CHK: begin
				if (d_sq > {{W{1'b0}}, rest_q} && rest_q <= W'(1)) status_q <= ST_OK;
				first_q <= 1'b0;
			end
			S_FAC_W: if (d_done && d_rem != '0) d_q <= d_q + W'(1);
			S_SUBP_W: if (d_done) first_q <= 1'b1;
			S_SUBQ: first_q <= 1'b0;
			S_SUBQ_W: begin
				if (first_q) begin
					if (p_done && p_pow == W'(1)) c_q <= c_q + W'(1);
					if (p_done && p_pow != W'(1) && d_sq > {{W{1'b0}}, rest_q})
						status_q <= ST_OK;
				end else if (d_done) begin
					// Quotient ord/rest for the leftover prime factor.
					t_q <= d_quo;
					first_q <= 1'b1;
				end
			end
			S_STRIP_W: if (d_done) begin
				if (d_rem == '0) rest_q <= d_quo;
				else d_q <= d_q + W'(1);
			end
			S_INVN_W: if (p_done) inv_n_q <= p_pow;
			S_INVH_W: begin
				if (p_done) begin
					inv_h_q <= (n_q >> 1 == '0) ? '0 : p_pow;
					t_q <= q_q;
				end
			end
			S_BITS: if (t_q != '0) begin
				t_q <= t_q >> 1;
				bits_q <= bits_q + 1'b1;
			end
			default: ;
		endcase
		if (st_q == S_SUBP_W && d_done) t_q <= d_quo;
	end

	assign busy = (st_q != S_IDLE);
	assign status = status_q;
	assign modulus_bits = (status_q == ST_OK) ? BITS_W'(bits_q) : '0;
	assign root_of_unity = (status_q == ST_OK) ? FIELD_W'(c_q) : '0;
	assign size_inverse = (status_q == ST_OK) ? FIELD_W'(inv_n_q) : '0;
	assign half_size_inverse = (status_q == ST_OK) ? FIELD_W'(inv_h_q) : '0;

	// A result strobe only closes a busy period.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without a word in work");
	// The block is back in idle in the cycle a result leaves.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("busy at result");
	// Errors carry zero value fields.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (root_of_unity == '0 && size_inverse == '0))
		else $error("error result with values");
endmodule
`default_nettype wire

// File: dv/tb_ntt_ring_parameter_derivation.sv
// Testbench for the NTT ring parameter derivation block: directed and random words, self-checked.
`default_nettype none
module tb_ntt_ring_parameter_derivation;
	timeunit 1ns;
	timeprecision 1ps;
	import nrpd_pkg::*;

	typedef struct {
		bit [15:0] q;
		bit [15:0] n;
	} ring_word_t;

	typedef struct {
		bit [1:0] st;
		bit [4:0] bits;
		bit [15:0] zeta;
		bit [15:0] inv_n;
		bit [15:0] inv_h;
	} ring_params_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [15:0] modulus;
	logic [15:0] ring_size;
	logic done;
	logic [1:0] status;
	logic [4:0] modulus_bits;
	logic [15:0] root_of_unity;
	logic [15:0] size_inverse;
	logic [15:0] half_size_inverse;

	ring_word_t pending_words[$];
	ring_params_t expected_params[$];
	int n_errors = 0;
	int n_accepted = 0;
	int n_total = 0;
	int n_status[4] = '{0, 0, 0, 0};
	int idle_left = 0;

	ntt_ring_parameter_derivation dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.modulus(modulus),
		.ring_size(ring_size),
		.done(done),
		.status(status),
		.modulus_bits(modulus_bits),
		.root_of_unity(root_of_unity),
		.size_inverse(size_inverse),
		.half_size_inverse(half_size_inverse)
	);

	// Clock with a 2 ns period.
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Modular exponentiation by square and multiply.
	function automatic longint unsigned pow_mod(longint unsigned b, longint unsigned e,
			longint unsigned m);
		longint unsigned r;
		r = 1 % m;
		b = b % m;
		while (e != 0) begin
			if (e[0])
				r = (r * b) % m;
			b = (b * b) % m;
			e = e >> 1;
		end
		return r;
	endfunction

	// Exact trial division, so square factors are caught.
	function automatic bit is_prime(longint unsigned v);
		longint unsigned d;
		if (v < 2)
			return 1'b0;
		for (d = 2; d * d <= v; d++)
			if (v % d == 0)
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic longint unsigned inverse_mod(longint unsigned a, longint unsigned m);
		a = a % m;
		if (a == 0)
			return 0;
		return pow_mod(a, m - 2, m);
	endfunction

	// True when c has multiplicative order exactly ord modulo the prime m.
	function automatic bit order_is(longint unsigned c, longint unsigned ord,
			longint unsigned m);
		longint unsigned rest;
		longint unsigned p;
		rest = ord;
		if (pow_mod(c, ord, m) != 1)
			return 1'b0;
		for (p = 2; p * p <= rest; p++) begin
			if (rest % p == 0) begin
				if (pow_mod(c, ord / p, m) == 1)
					return 1'b0;
				while (rest % p == 0)
					rest = rest / p;
			end
		end
		if (rest > 1 && pow_mod(c, ord / rest, m) == 1)
			return 1'b0;
		return 1'b1;
	endfunction

	// Derive the ring parameters that one word should produce.
	function automatic ring_params_t derive_params(ring_word_t w);
		ring_params_t r;
		longint unsigned q;
		longint unsigned n;
		longint unsigned c;
		longint unsigned t;
		longint unsigned z;
		q = w.q;
		n = w.n;
		z = 0;
		r = '{ST_OK, 5'd0, 16'd0, 16'd0, 16'd0};
		if (!is_prime(q)) begin
			r.st = ST_NOT_PRIME;
		end else if (n == 0 || (q - 1) % n != 0) begin
			r.st = ST_NO_DIVIDE;
		end else begin
			if ((q - 1) % (2 * n) == 0) begin
				for (c = 2; c < q; c++) begin
					if (order_is(c, 2 * n, q)) begin
						z = c;
						break;
					end
				end
			end
			if (z == 0) begin
				r.st = ST_NO_ROOT;
			end else begin
				r.zeta = z[15:0];
				for (t = q; t != 0; t = t >> 1)
					r.bits++;
				r.inv_n = 16'(inverse_mod(n, q));
				r.inv_h = 16'(inverse_mod(n / 2, q));
			end
		end
		return r;
	endfunction

	// Queue a word unless its root search would run far too long in hardware.
	function automatic void add_word(bit [15:0] q, bit [15:0] n);
		ring_word_t w;
		ring_params_t p;
		w = '{q, n};
		p = derive_params(w);
		if (p.st == ST_OK && p.zeta > 400)
			return;
		pending_words.push_back(w);
	endfunction

	function automatic bit [15:0] random_prime();
		bit [15:0] q;
		int top;
		top = ($urandom_range(0, 3) == 0) ? 255 : 65535;
		do
			q = 16'($urandom_range(3, top));
		while (!is_prime(q));
		return q;
	endfunction

	// Driver: present the next word and hold it until the block takes it.
	always @(posedge clk or negedge arst_n) begin
		ring_word_t w;
		logic next_start;
		if (!arst_n) begin
			start <= 1'b0;
			modulus <= '0;
			ring_size <= '0;
		end else begin
			next_start = start;
			if (start && !busy) begin
				expected_params.push_back(derive_params('{modulus, ring_size}));
				n_accepted++;
				next_start = 1'b0;
			end
			if (!next_start) begin
				if (idle_left > 0) begin
					idle_left--;
				end else if (pending_words.size() > 0) begin
					w = pending_words.pop_front();
					modulus <= w.q;
					ring_size <= w.n;
					next_start = 1'b1;
					if (pending_words.size() > 20 && $urandom_range(0, 3) == 0)
						idle_left = $urandom_range(1, 10);
				end
			end
			start <= next_start;
		end
	end

	// Monitor: check each result word against the oldest expectation.
	always @(posedge clk) begin
		ring_params_t e;
		if (arst_n && done) begin
			if (expected_params.size() == 0) begin
				$error("result word with no expectation waiting");
				n_errors++;
			end else begin
				e = expected_params.pop_front();
				n_status[e.st]++;
				if (status !== e.st) begin
					$error("status: expected %0d, actual %0d", e.st, status);
					n_errors++;
				end
				if (modulus_bits !== e.bits) begin
					$error("modulus_bits: expected %0d, actual %0d", e.bits, modulus_bits);
					n_errors++;
				end
				if (root_of_unity !== e.zeta) begin
					$error("root_of_unity: expected %0d, actual %0d", e.zeta, root_of_unity);
					n_errors++;
				end
				if (size_inverse !== e.inv_n) begin
					$error("size_inverse: expected %0d, actual %0d", e.inv_n, size_inverse);
					n_errors++;
				end
				if (half_size_inverse !== e.inv_h) begin
					$error("half_size_inverse: expected %0d, actual %0d", e.inv_h,
						half_size_inverse);
					n_errors++;
				end
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		bit [15:0] q;
		int k;
		int mode;
		arst_n = 1'b0;
		// Directed words: small moduli, squares, extremes and every status.
		add_word(16'd0, 16'd1);
		add_word(16'd1, 16'd1);
		add_word(16'd2, 16'd1);
		add_word(16'd3, 16'd1);
		add_word(16'd4, 16'd2);
		add_word(16'd9, 16'd2);
		add_word(16'd25, 16'd4);
		add_word(16'd65535, 16'd65535);
		add_word(16'd65521, 16'd0);
		add_word(16'd65521, 16'd32760);
		add_word(16'd65521, 16'd16380);
		add_word(16'd65521, 16'd65520);
		add_word(16'd65521, 16'd65535);
		add_word(16'd17, 16'd8);
		add_word(16'd17, 16'd1);
		add_word(16'd17, 16'd16);
		add_word(16'd17, 16'd3);
		add_word(16'd7, 16'd3);
		add_word(16'd5, 16'd2);
		add_word(16'd13, 16'd6);
		add_word(16'd97, 16'd48);
		add_word(16'd12289, 16'd512);
		add_word(16'd7681, 16'd256);
		add_word(16'd3329, 16'd128);
		// Random words, mostly well formed rings with a root to find.
		while (pending_words.size() < 100) begin
			mode = $urandom_range(0, 19);
			if (mode < 11) begin
				q = random_prime();
				do
					k = $urandom_range(1, 8);
				while ((q - 1) % (2 * k) != 0);
				add_word(q, 16'((q - 1) / (2 * k)));
			end else if (mode < 14) begin
				q = random_prime();
				do
					k = 2 * $urandom_range(0, 4) + 1;
				while ((q - 1) % k != 0);
				add_word(q, 16'((q - 1) / k));
			end else if (mode < 16) begin
				add_word(random_prime(), 16'($urandom_range(0, 65535)));
			end else begin
				add_word(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
			end
		end
		n_total = pending_words.size();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		wait (n_accepted == n_total && expected_params.size() == 0);
		repeat (100) @(posedge clk);
		$display("Checked %0d words: %0d ok, %0d not prime, %0d no divide, %0d no root.",
			n_total, n_status[ST_OK], n_status[ST_NOT_PRIME], n_status[ST_NO_DIVIDE],
			n_status[ST_NO_ROOT]);
		if (n_errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Watchdog against a hung block.
	initial begin
		#250_000_000;
		$display("FAILURE");
		$finish;
	end
endmodule
`default_nettype wire

// File: sim.f
hdl/nrpd_pkg.sv
hdl/nrpd_divider.sv
hdl/nrpd_modmul.sv
hdl/ntt_ring_parameter_derivation.sv
dv/tb_ntt_ring_parameter_derivation.sv
